/* design/ensc_pkg.sv */
`default_nettype none

package ensc_pkg;

  // Width of the pressure datapath words.
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned HALF_W = WIDE_W / 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HUM_CALIB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CALIB       = 3'd4;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic [16:0]        humidity_q22_10;
  } out_item_t;

endpackage

`default_nettype wire

/* design/env_sensor_compensation.sv */
`default_nettype none

// Channel  | Signals                         | Transfer when
// ---------+---------------------------------+-----------------------------
// input    | in_valid, in_stall, in_data     | in_valid high, in_stall low
// output   | out_valid, out_stall, out_data  | out_valid high, out_stall low
// config   | cfg_write, cfg_index, cfg_data  | cfg_write high
//
// One sample enters every cycle while the pipeline is not held. The
// pipeline depth is set by the 66-stage pressure divider, which works
// one quotient bit per stage, plus the multiplier stages around it.
// Reset (synchronous) clears all valid bits and the calibration registers.
// The whole pipeline holds when the output register is full and stalled;
// in_stall is high in exactly those cycles.
module env_sensor_compensation (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire ensc_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output ensc_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_write,
  input  wire logic [ensc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ensc_pkg::WIDE_W-1:0]        cfg_data
);

  // Pipeline depth and where the side paths join the output stage.
  localparam int unsigned DEPTH   = 85;
  localparam int unsigned TC_LEN  = 80;  // temperature ready after stage 5
  localparam int unsigned HUM_LEN = 70;  // humidity ready after stage 15
  localparam int unsigned PV_LEN  = 71;  // divisor check ready after stage 14
  localparam int unsigned RP_LEN  = 9;   // raw pressure used in stage 11
  localparam int unsigned RH_LEN  = 5;   // raw humidity used in stage 7
  localparam int unsigned P_LEN   = 4;   // quotient held from stage 79 to 83

  function automatic logic [31:0] asr32(input logic [31:0] a, input logic [5:0] n);
    asr32 = $signed(a) >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] a, input logic [5:0] n);
    asr64 = $signed(a) >>> n;
  endfunction

  // Calibration registers.
  logic [47:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [47:0] press_hum_calib;
  logic [39:0] hum_calib;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib      <= '0;
      press_calib_a   <= '0;
      press_calib_b   <= '0;
      press_hum_calib <= '0;
      hum_calib       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ensc_pkg::REG_TEMP_CALIB:      temp_calib      <= cfg_data[47:0];
        ensc_pkg::REG_PRESS_CALIB_A:   press_calib_a   <= cfg_data;
        ensc_pkg::REG_PRESS_CALIB_B:   press_calib_b   <= cfg_data;
        ensc_pkg::REG_PRESS_HUM_CALIB: press_hum_calib <= cfg_data[47:0];
        ensc_pkg::REG_HUM_CALIB:       hum_calib       <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // Unpacked calibration words, extended to the width of their datapath.
  logic [31:0] t1c, t2c, t3c;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1c = {16'd0, temp_calib[15:0]};
  assign t2c = {{16{temp_calib[31]}}, temp_calib[31:16]};
  assign t3c = {{16{temp_calib[47]}}, temp_calib[47:32]};
  assign p1  = {48'd0, press_calib_a[15:0]};
  assign p2  = {{48{press_calib_a[31]}}, press_calib_a[31:16]};
  assign p3  = {{48{press_calib_a[47]}}, press_calib_a[47:32]};
  assign p4  = {{48{press_calib_a[63]}}, press_calib_a[63:48]};
  assign p5  = {{48{press_calib_b[15]}}, press_calib_b[15:0]};
  assign p6  = {{48{press_calib_b[31]}}, press_calib_b[31:16]};
  assign p7  = {{48{press_calib_b[47]}}, press_calib_b[47:32]};
  assign p8  = {{48{press_calib_b[63]}}, press_calib_b[63:48]};
  assign p9  = {{48{press_hum_calib[15]}}, press_hum_calib[15:0]};
  assign h1  = {24'd0, press_hum_calib[23:16]};
  assign h2  = {{16{press_hum_calib[39]}}, press_hum_calib[39:24]};
  assign h3  = {24'd0, press_hum_calib[47:40]};
  assign h4  = {{16{hum_calib[15]}}, hum_calib[15:0]};
  assign h5  = {{16{hum_calib[31]}}, hum_calib[31:16]};
  assign h6  = {{24{hum_calib[39]}}, hum_calib[39:32]};

  // The pipeline advances as one unit unless the output register is blocked.
  logic adv;
  logic vld [0:DEPTH-1];

  assign adv       = !(vld[DEPTH-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) vld[i] <= vld[i-1];
    end
  end

  // Stage registers, named by the stage that writes them.
  logic [19:0] s1_rt, s1_rp;
  logic [15:0] s1_rh;
  logic [19:0] rp_d [0:RP_LEN-1];
  logic [15:0] rh_d [0:RH_LEN-1];
  logic [31:0] s2_ma, s2_dd, s3_v1, s3_mb, s4_tfine;
  logic [63:0] s5_q1;
  logic [31:0] s5_x;
  logic [31:0] tc_d [0:TC_LEN-1];

  logic [31:0] s6_mh5, s6_m6, s6_m3;
  logic [31:0] s7_ha, s7_a6, s7_b3;
  logic [31:0] s8_hb0, s8_ha, s9_hb1, s9_ha, s10_hb2, s10_ha, s11_hb, s11_ha;
  logic [31:0] s12_xh, s13_s2, s13_xh, s14_m, s14_xh;
  logic [16:0] hum_d [0:HUM_LEN-1];

  logic [63:0] qq7, qp5_7, qp2_7, d9, e9;
  logic [63:0] s8_qp5, s9_qp5, s8_qp2, s9_qp2;
  logic [63:0] s10_q2, s10_q1b, s11_q1c, s11_n0;
  logic [63:0] f13, n13, den13, p79;
  logic        pv_d [0:PV_LEN-1];
  logic [63:0] p_d  [0:P_LEN-1];
  logic [63:0] ss81, pp81, q83, s82_r2, s83_r2, s84_sum;

  // Combinational helpers inside stages.
  logic [31:0] d2, tf5, x15, s12_s, pf_lo;
  logic [63:0] pf, s79_s;

  assign d2    = {16'd0, s1_rt[19:4]} - t1c;
  assign tf5   = {s4_tfine[29:0], 2'b00} + s4_tfine + 32'd128;
  assign s12_s = asr32(s12_xh, 6'd15);
  assign x15   = s14_xh - asr32(s14_m, 6'd4);
  assign den13 = asr64(f13, 6'd33);
  assign s79_s = asr64(p79, 6'd13);
  assign pf    = asr64(s84_sum, 6'd8) + {p7[59:0], 4'd0};
  assign pf_lo = pf[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: input capture.
      s1_rt <= in_data.raw_temperature;
      s1_rp <= in_data.raw_pressure;
      s1_rh <= in_data.raw_humidity;
      rp_d[0] <= s1_rp;
      for (int i = 1; i < RP_LEN; i++) rp_d[i] <= rp_d[i-1];
      rh_d[0] <= s1_rh;
      for (int i = 1; i < RH_LEN; i++) rh_d[i] <= rh_d[i-1];

      // Stages 2 to 4: fine temperature.
      s2_ma    <= ({15'd0, s1_rt[19:3]} - {t1c[30:0], 1'b0}) * t2c;
      s2_dd    <= d2 * d2;
      s3_v1    <= asr32(s2_ma, 6'd11);
      s3_mb    <= asr32(s2_dd, 6'd12) * t3c;
      s4_tfine <= s3_v1 + asr32(s3_mb, 6'd14);

      // Stage 5: temperature result and offsets for the other two paths.
      tc_d[0] <= asr32(tf5, 6'd8);
      for (int i = 1; i < TC_LEN; i++) tc_d[i] <= tc_d[i-1];
      s5_q1 <= {{32{s4_tfine[31]}}, s4_tfine} - 64'd128000;
      s5_x  <= s4_tfine - 32'd76800;

      // Stages 6 to 15: humidity in 32-bit wrapping arithmetic.
      s6_mh5  <= h5 * s5_x;
      s6_m6   <= s5_x * h6;
      s6_m3   <= s5_x * h3;
      s7_ha   <= asr32({2'b00, rh_d[RH_LEN-1], 14'd0} - {h4[11:0], 20'd0} - s6_mh5
                       + 32'd16384, 6'd15);
      s7_a6   <= asr32(s6_m6, 6'd10);
      s7_b3   <= asr32(s6_m3, 6'd11) + 32'd32768;
      s8_hb0  <= s7_a6 * s7_b3;
      s8_ha   <= s7_ha;
      s9_hb1  <= asr32(s8_hb0, 6'd10) + 32'd2097152;
      s9_ha   <= s8_ha;
      s10_hb2 <= s9_hb1 * h2;
      s10_ha  <= s9_ha;
      s11_hb  <= asr32(s10_hb2 + 32'd8192, 6'd14);
      s11_ha  <= s10_ha;
      s12_xh  <= s11_ha * s11_hb;
      s13_s2  <= s12_s * s12_s;
      s13_xh  <= s12_xh;
      s14_m   <= asr32(s13_s2, 6'd7) * h1;
      s14_xh  <= s13_xh;
      // Clamp to 0..100 percent before dropping the 12 extra fraction bits.
      if (x15[31]) begin
        hum_d[0] <= '0;
      end else if (x15 > 32'd419430400) begin
        hum_d[0] <= 17'd102400;
      end else begin
        hum_d[0] <= x15[28:12];
      end
      for (int i = 1; i < HUM_LEN; i++) hum_d[i] <= hum_d[i-1];

      // Pressure: the multiplies run in their own two-stage units below.
      s8_qp5  <= qp5_7;
      s9_qp5  <= s8_qp5;
      s8_qp2  <= qp2_7;
      s9_qp2  <= s8_qp2;
      s10_q2  <= d9 + {s9_qp5[46:0], 17'd0} + {p4[28:0], 35'd0};
      s10_q1b <= asr64(e9, 6'd8) + {s9_qp2[51:0], 12'd0};
      s11_q1c <= 64'h0000_8000_0000_0000 + s10_q1b;
      s11_n0  <= {12'd0, (21'd1048576 - {1'b0, rp_d[RP_LEN-1]}), 31'd0} - s10_q2;

      // A zero divisor leaves the quotient meaningless; this flag masks it.
      pv_d[0] <= (den13 != '0);
      for (int i = 1; i < PV_LEN; i++) pv_d[i] <= pv_d[i-1];

      p_d[0] <= p79;
      for (int i = 1; i < P_LEN; i++) p_d[i] <= p_d[i-1];
      s82_r2  <= asr64(pp81, 6'd19);
      s83_r2  <= s82_r2;
      s84_sum <= p_d[P_LEN-1] + asr64(q83, 6'd25) + s83_r2;

      // Stage 85: output register with pressure saturation.
      out_data.temperature_centi <= tc_d[TC_LEN-1];
      out_data.humidity_q22_10   <= hum_d[HUM_LEN-1];
      out_data.pressure_valid    <= pv_d[PV_LEN-1];
      if (!pv_d[PV_LEN-1] || pf[63]) begin
        out_data.pressure_q24_8 <= '0;
      end else if (pf[62:32] != '0) begin
        out_data.pressure_q24_8 <= '1;
      end else begin
        out_data.pressure_q24_8 <= pf_lo;
      end
    end
  end

  // q1 squared and the linear pressure terms (stages 6 to 7).
  ensc_mul64 u_mul_qq  (.clk, .en(adv), .a(s5_q1), .b(s5_q1), .y(qq7));
  ensc_mul64 u_mul_qp5 (.clk, .en(adv), .a(s5_q1), .b(p5),    .y(qp5_7));
  ensc_mul64 u_mul_qp2 (.clk, .en(adv), .a(s5_q1), .b(p2),    .y(qp2_7));

  // Quadratic terms (stages 8 to 9).
  ensc_mul64 u_mul_qp6 (.clk, .en(adv), .a(qq7), .b(p6), .y(d9));
  ensc_mul64 u_mul_qp3 (.clk, .en(adv), .a(qq7), .b(p3), .y(e9));

  // Divisor and scaled dividend (stages 12 to 13).
  ensc_mul64 u_mul_p1  (.clk, .en(adv), .a(s11_q1c), .b(p1),        .y(f13));
  ensc_mul64 u_mul_num (.clk, .en(adv), .a(s11_n0),  .b(64'd3125),  .y(n13));

  // Division (stages 14 to 79).
  ensc_div u_div (
    .clk,
    .en       (adv),
    .dividend (n13),
    .divisor  (den13),
    .quotient (p79)
  );

  // Second-order corrections on the quotient (stages 80 to 83).
  ensc_mul64 u_mul_ss  (.clk, .en(adv), .a(s79_s), .b(s79_s), .y(ss81));
  ensc_mul64 u_mul_pp8 (.clk, .en(adv), .a(p79),   .b(p8),    .y(pp81));
  ensc_mul64 u_mul_p9  (.clk, .en(adv), .a(ss81),  .b(p9),    .y(q83));

endmodule

`default_nettype wire

/* design/ensc_mul64.sv */
`default_nettype none

// Two-stage 64 x 64 multiplier keeping the low 64 bits of the product.
module ensc_mul64 (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [ensc_pkg::WIDE_W-1:0]      a,
  input  wire logic [ensc_pkg::WIDE_W-1:0]      b,
  output logic      [ensc_pkg::WIDE_W-1:0]      y
);

  localparam int unsigned H = ensc_pkg::HALF_W;

  logic [2*H-1:0] ll;
  logic [H-1:0]   lh;
  logic [H-1:0]   hl;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[H-1:0] * b[H-1:0];
      lh <= a[H-1:0] * b[2*H-1:H];
      hl <= a[2*H-1:H] * b[H-1:0];
      y  <= ll + {lh + hl, {H{1'b0}}};
    end
  end

endmodule

`default_nettype wire

/* design/ensc_div.sv */
`default_nettype none

// Pipelined signed 64-bit divider, one quotient bit per stage.
// Its stages are one for magnitudes, one per bit, one for the sign.
module ensc_div (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [ensc_pkg::WIDE_W-1:0]  dividend,
  input  wire logic [ensc_pkg::WIDE_W-1:0]  divisor,
  output logic      [ensc_pkg::WIDE_W-1:0]  quotient
);

  localparam int unsigned W = ensc_pkg::WIDE_W;

  logic [W-1:0] rem [0:W];
  logic [W-1:0] qd  [0:W];
  logic [W-1:0] dvs [0:W];
  logic         neg [0:W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      qd[0]  <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
      dvs[0] <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
      neg[0] <= dividend[W-1] ^ divisor[W-1];
      quotient <= neg[W] ? (~qd[W] + 1'b1) : qd[W];
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_bit
    logic [W-1:0] sh;
    assign sh = {rem[i][W-2:0], qd[i][W-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (sh >= dvs[i]) begin
          rem[i+1] <= sh - dvs[i];
          qd[i+1]  <= {qd[i][W-2:0], 1'b1};
        end else begin
          rem[i+1] <= sh;
          qd[i+1]  <= {qd[i][W-2:0], 1'b0};
        end
        dvs[i+1] <= dvs[i];
        neg[i+1] <= neg[i];
      end
    end
  end

endmodule

`default_nettype wire

/* dv/env_sensor_compensation_checker.sv */
`default_nettype none

module env_sensor_compensation_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire ensc_pkg::in_item_t                  in_data,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire ensc_pkg::out_item_t                 out_data,
  input  wire logic                                cfg_write,
  input  wire logic [ensc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ensc_pkg::WIDE_W-1:0]         cfg_data,
  output int                                       errors,
  output int                                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] t_cal;
  logic [63:0] pa_cal, pb_cal;
  logic [47:0] ph_cal;
  logic [39:0] h_cal;
  ensc_pkg::out_item_t expected_q[$];

  function automatic logic signed [63:0] sdiv_trunc(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic ensc_pkg::out_item_t compensate(ensc_pkg::in_item_t s);
    ensc_pkg::out_item_t r;
    logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic signed [31:0] at, ah, v1, d, v2, fine, x, ha, hb, hs;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, q1, q2, p, k1, k2, ap;
    t1 = {16'd0, t_cal[15:0]};
    t2 = {{16{t_cal[31]}}, t_cal[31:16]};
    t3 = {{16{t_cal[47]}}, t_cal[47:32]};
    p1 = {48'd0, pa_cal[15:0]};
    p2 = {{48{pa_cal[31]}}, pa_cal[31:16]};
    p3 = {{48{pa_cal[47]}}, pa_cal[47:32]};
    p4 = {{48{pa_cal[63]}}, pa_cal[63:48]};
    p5 = {{48{pb_cal[15]}}, pb_cal[15:0]};
    p6 = {{48{pb_cal[31]}}, pb_cal[31:16]};
    p7 = {{48{pb_cal[47]}}, pb_cal[47:32]};
    p8 = {{48{pb_cal[63]}}, pb_cal[63:48]};
    p9 = {{48{ph_cal[15]}}, ph_cal[15:0]};
    h1 = {24'd0, ph_cal[23:16]};
    h2 = {{16{ph_cal[39]}}, ph_cal[39:24]};
    h3 = {24'd0, ph_cal[47:40]};
    h4 = {{16{h_cal[15]}}, h_cal[15:0]};
    h5 = {{16{h_cal[31]}}, h_cal[31:16]};
    h6 = {{24{h_cal[39]}}, h_cal[39:32]};
    at = {12'd0, s.raw_temperature};
    ah = {16'd0, s.raw_humidity};
    ap = {44'd0, s.raw_pressure};

    v1 = (((at >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = (at >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    r.temperature_centi = (fine * 5 + 128) >>> 8;

    q1 = 64'(fine) - 64'sd128000;
    q2 = q1 * q1 * p6;
    q2 = q2 + ((q1 * p5) <<< 17);
    q2 = q2 + (p4 <<< 35);
    q1 = ((q1 * q1 * p3) >>> 8) + ((q1 * p2) <<< 12);
    q1 = ((64'sd1 <<< 47) + q1) * p1;
    q1 = q1 >>> 33;
    r.pressure_q24_8 = '0;
    r.pressure_valid = 1'b0;
    if (q1 != 0) begin
      p = 64'sd1048576 - ap;
      p = sdiv_trunc(((p <<< 31) - q2) * 64'sd3125, q1);
      k1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      k2 = (p8 * p) >>> 19;
      p = ((p + k1 + k2) >>> 8) + (p7 <<< 4);
      if (p < 0) r.pressure_q24_8 = '0;
      else if (p > 64'sh0FFFF_FFFF) r.pressure_q24_8 = 32'hFFFF_FFFF;
      else r.pressure_q24_8 = p[31:0];
      r.pressure_valid = 1'b1;
    end

    x = fine - 32'sd76800;
    ha = ((ah <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384) >>> 15;
    hb = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768);
    hb = (hb >>> 10) + 32'sd2097152;
    hb = (hb * h2 + 32'sd8192) >>> 14;
    x = ha * hb;
    hs = x >>> 15;
    x = x - ((((hs * hs) >>> 7) * h1) >>> 4);
    if (x < 0) x = 0;
    else if (x > 32'sd419430400) x = 32'sd419430400;
    r.humidity_q22_10 = x[28:12];
    return r;
  endfunction

  always @(posedge clk) begin
    ensc_pkg::out_item_t e;
    int bad;
    bad = 0;
    if (rst) begin
      t_cal <= '0;
      pa_cal <= '0;
      pb_cal <= '0;
      ph_cal <= '0;
      h_cal <= '0;
      errors <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(compensate(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no sample outstanding");
          bad++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.temperature_centi !== e.temperature_centi) begin
            $error("temperature_centi exp %0d got %0d", e.temperature_centi,
                   out_data.temperature_centi);
            bad++;
          end
          if (out_data.pressure_q24_8 !== e.pressure_q24_8) begin
            $error("pressure_q24_8 exp %h got %h", e.pressure_q24_8,
                   out_data.pressure_q24_8);
            bad++;
          end
          if (out_data.pressure_valid !== e.pressure_valid) begin
            $error("pressure_valid exp %b got %b", e.pressure_valid,
                   out_data.pressure_valid);
            bad++;
          end
          if (out_data.humidity_q22_10 !== e.humidity_q22_10) begin
            $error("humidity_q22_10 exp %0d got %0d", e.humidity_q22_10,
                   out_data.humidity_q22_10);
            bad++;
          end
        end
      end
      errors <= errors + bad;
      pending <= expected_q.size();
      if (cfg_write) begin
        case (cfg_index)
          ensc_pkg::REG_TEMP_CALIB:      t_cal <= cfg_data[47:0];
          ensc_pkg::REG_PRESS_CALIB_A:   pa_cal <= cfg_data;
          ensc_pkg::REG_PRESS_CALIB_B:   pb_cal <= cfg_data;
          ensc_pkg::REG_PRESS_HUM_CALIB: ph_cal <= cfg_data[47:0];
          ensc_pkg::REG_HUM_CALIB:       h_cal <= cfg_data[39:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* dv/env_sensor_compensation_test.sv */
`default_nettype none

module env_sensor_compensation_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Settling time that drain waits after the last result has been checked.
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_write;
  ensc_pkg::in_item_t in_data;
  ensc_pkg::out_item_t out_data;
  logic [ensc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ensc_pkg::WIDE_W-1:0] cfg_data;
  int errors, pending;
  int cycle_count;
  // When set, the result side holds its stall for a long run of cycles.
  logic hold_results;

  env_sensor_compensation dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  env_sensor_compensation_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: a random stall length per transfer, with stall-free stretches
  // and one long hold-off that lets the pipeline fill and back up the input.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (cycle_count % 4000 < 800) gap = 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic write_calib(logic [ensc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits for every outstanding result, then lets the pipeline settle.
  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offers one sample, after a random gap unless no_gap is set, and holds it until the transfer.
  task automatic send_sample(ensc_pkg::in_item_t s, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic ensc_pkg::in_item_t random_sample();
    ensc_pkg::in_item_t s;
    s.raw_temperature = 20'($urandom());
    s.raw_pressure = 20'($urandom());
    s.raw_humidity = 16'($urandom());
    case ($urandom_range(0, 9))
      0: s.raw_temperature = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      1: s.raw_pressure = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      2: s.raw_humidity = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      default: begin
        // Typical conversion ranges keep the compensation in its working area.
        if ($urandom_range(0, 2) != 0) begin
          s.raw_temperature = 20'($urandom_range(380000, 620000));
          s.raw_pressure = 20'($urandom_range(250000, 450000));
          s.raw_humidity = 16'($urandom_range(20000, 40000));
        end
      end
    endcase
    return s;
  endfunction

  // Writes one calibration set: 0 = zeros, 1 = all ones, 2 = typical device
  // values with random trim, 3 = fully random words.
  task automatic load_calib(int flavor);
    logic [63:0] w0, w1, w2, w3, w4;
    case (flavor)
      0: {w0, w1, w2, w3, w4} = '0;
      1: {w0, w1, w2, w3, w4} = '1;
      2: begin
        w0 = {16'd0, 16'(50 + $urandom_range(0, 20)), 16'(26400 + $urandom_range(0, 800)),
              16'(27500 + $urandom_range(0, 1000))};
        w1 = {16'(8000 + $urandom_range(0, 2000)), 16'(3000 + $urandom_range(0, 500)),
              -16'sd10600, 16'(36000 + $urandom_range(0, 2000))};
        w2 = {16'(-16'sd12000), 16'(15000 + $urandom_range(0, 400)),
              16'(-16'sd7), 16'(-16'sd100)};
        w3 = {16'd0, 8'd0, 16'(370 + $urandom_range(0, 20)), 8'd75, 16'(6000)};
        w4 = {24'd0, 8'sd30, 16'sd50, 16'(300 + $urandom_range(0, 40))};
      end
      default: begin
        w0 = {$urandom(), $urandom()};
        w1 = {$urandom(), $urandom()};
        w2 = {$urandom(), $urandom()};
        w3 = {$urandom(), $urandom()};
        w4 = {$urandom(), $urandom()};
      end
    endcase
    write_calib(ensc_pkg::REG_TEMP_CALIB, w0);
    write_calib(ensc_pkg::REG_PRESS_CALIB_A, w1);
    write_calib(ensc_pkg::REG_PRESS_CALIB_B, w2);
    write_calib(ensc_pkg::REG_PRESS_HUM_CALIB, w3);
    write_calib(ensc_pkg::REG_HUM_CALIB, w4);
  endtask

  initial begin
    ensc_pkg::in_item_t s;
    int phase;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_results = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: with zero calibration the pressure divisor is zero, then
    // typical calibration with extreme raw fields and random samples.
    s = '0;
    send_sample(s, 0);
    s = '1;
    send_sample(s, 0);
    in_valid <= 1'b0;
    drain_results();
    load_calib(2);
    for (int i = 0; i < 16; i++) begin
      s.raw_temperature = i[0] ? 20'hFFFFF : 20'h0;
      s.raw_pressure = i[1] ? 20'hFFFFF : 20'h0;
      s.raw_humidity = i[2] ? 16'hFFFF : 16'h0;
      if (i[3]) s = random_sample();
      send_sample(s, 0);
    end
    in_valid <= 1'b0;
    drain_results();

    // Random phases across calibration flavors; one phase runs back to back
    // against a long result hold-off so the input backs up.
    for (phase = 0; phase < 12; phase++) begin
      load_calib(phase == 1 ? 1 : phase == 5 ? 0 : (phase % 3 == 0 ? 3 : 2));
      if (phase == 4) hold_results = 1'b1;
      for (int i = 0; i < 86; i++) send_sample(random_sample(), phase == 4);
      in_valid <= 1'b0;
      drain_results();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/ensc_pkg.sv
design/ensc_mul64.sv
design/ensc_div.sv
design/env_sensor_compensation.sv
dv/env_sensor_compensation_checker.sv
dv/env_sensor_compensation_test.sv
